// ===== src/clock_skew_rls_estimator_unit_defines.svh =====
// Assertion macros used by the clock skew estimator unit.
`ifndef CLOCK_SKEW_RLS_ESTIMATOR_UNIT_DEFINES_SVH
`define CLOCK_SKEW_RLS_ESTIMATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define CSKE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define CSKE_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define CSKE_ASSERT(lbl, clk, rstn, prop, msg)
`define CSKE_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

// ===== src/cske_pkg.sv =====
`default_nettype none
package cske_pkg;

    localparam int FRAC_BITS = 32;
    localparam int IN_W      = 16;
    localparam int G_W       = 64;
    localparam int OUT_W     = 48;
    localparam int MAG_W     = 128;
    localparam int ACC_W     = 130;
    localparam int MUL_STEPS = 64;
    localparam int DIV_STEPS = 128;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [G_W-1:0]   g_t;
    typedef logic signed [OUT_W-1:0] est_t;
    typedef logic signed [IN_W-1:0]  smp_t;

    localparam acc_t ACC_UNIT = {{(ACC_W-1){1'b0}}, 1'b1};
    localparam acc_t ONE_Q    = ACC_UNIT <<< FRAC_BITS;
    // 2.0 in the matrix format
    localparam g_t   G_TWO    = g_t'(ACC_UNIT <<< (FRAC_BITS + 1));

    localparam g_t   G_MAX     = {1'b0, {(G_W-1){1'b1}}};
    localparam g_t   G_MIN     = {1'b1, {(G_W-1){1'b0}}};
    localparam acc_t G_MAX_ACC = {{(ACC_W-G_W+1){1'b0}}, {(G_W-1){1'b1}}};
    localparam acc_t G_MIN_ACC = {{(ACC_W-G_W+1){1'b1}}, {(G_W-1){1'b0}}};
    localparam est_t E_MAX     = {1'b0, {(OUT_W-1){1'b1}}};
    localparam est_t E_MIN     = {1'b1, {(OUT_W-1){1'b0}}};
    localparam acc_t E_MAX_ACC = {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam acc_t E_MIN_ACC = {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    typedef enum logic {
        MDU_MUL,
        MDU_DIV
    } mdu_op_t;

    typedef struct packed {
        logic    start;
        mdu_op_t op;
    } mdu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mdu_sts_t;

    typedef enum logic [1:0] {
        PH_EMPTY,
        PH_ONE,
        PH_FIT
    } phase_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_I_SQ1,
        ST_I_SQ2,
        ST_I_XY1,
        ST_I_XY2,
        ST_U_XG0,
        ST_U_XG1,
        ST_U_XG2,
        ST_U_P,
        ST_U_MUL,
        ST_U_DIV,
        ST_U_XY,
        ST_E_SK1,
        ST_E_SK2,
        ST_E_IC1,
        ST_E_IC2,
        ST_OUT
    } state_t;

    function automatic acc_t ext64(input g_t v);
        return {{(ACC_W-G_W){v[G_W-1]}}, v};
    endfunction

    function automatic acc_t ext16(input smp_t v);
        return {{(ACC_W-IN_W){v[IN_W-1]}}, v};
    endfunction

    function automatic g_t sat64(input acc_t v);
        if (v > G_MAX_ACC) begin
            return G_MAX;
        end else if (v < G_MIN_ACC) begin
            return G_MIN;
        end
        return v[G_W-1:0];
    endfunction

    function automatic est_t sat48(input acc_t v);
        if (v > E_MAX_ACC) begin
            return E_MAX;
        end else if (v < E_MIN_ACC) begin
            return E_MIN;
        end
        return v[OUT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/cske_mdu.sv =====
`default_nettype none
// Shared sign-magnitude multiply / divide unit.
// MUL: a (64-bit value) * b, one bit of b per cycle.
// DIV: a / b over 128 quotient bits, rounded half away from zero, zero if b is zero.
module cske_mdu (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cske_pkg::mdu_req_t req,
    input  wire cske_pkg::acc_t    a,
    input  wire cske_pkg::g_t      b,
    output cske_pkg::mdu_sts_t     sts,
    output cske_pkg::acc_t         res
);

    localparam logic [cske_pkg::CNT_W-1:0] MUL_LAST =
        cske_pkg::CNT_W'(cske_pkg::MUL_STEPS - 1);
    localparam logic [cske_pkg::CNT_W-1:0] DIV_LAST =
        cske_pkg::CNT_W'(cske_pkg::DIV_STEPS - 1);

    logic                        busy_reg, busy_next;
    logic                        fin_reg, fin_next;
    logic                        done_reg, done_next;
    cske_pkg::mdu_op_t           op_reg, op_next;
    logic                        neg_reg, neg_next;
    logic [cske_pkg::MAG_W-1:0]  mag_a_reg, mag_a_next;
    logic [cske_pkg::G_W-1:0]    mag_b_reg, mag_b_next;
    logic [cske_pkg::MAG_W-1:0]  acc_reg, acc_next;
    logic [cske_pkg::G_W-1:0]    rem_reg, rem_next;
    logic [cske_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    cske_pkg::acc_t              res_reg, res_next;

    cske_pkg::acc_t              abs_a;
    logic [cske_pkg::G_W-1:0]    abs_b;
    logic [cske_pkg::G_W:0]      rem_sh;
    logic [cske_pkg::G_W:0]      rem_diff;
    logic                        ge;
    logic                        round_up;
    logic [cske_pkg::MAG_W-1:0]  mag_out;
    cske_pkg::acc_t              res_mag;

    always_comb begin
        abs_a    = a[cske_pkg::ACC_W-1] ? -a : a;
        abs_b    = b[cske_pkg::G_W-1] ? cske_pkg::G_W'(-b) : cske_pkg::G_W'(b);
        rem_sh   = {rem_reg, mag_a_reg[cske_pkg::MAG_W-1]};
        rem_diff = rem_sh - {1'b0, mag_b_reg};
        ge       = rem_sh >= {1'b0, mag_b_reg};
        round_up = {rem_reg, 1'b0} >= {1'b0, mag_b_reg};
        if (op_reg == cske_pkg::MDU_MUL) begin
            mag_out = acc_reg;
        end else if (mag_b_reg == '0) begin
            mag_out = '0;
        end else begin
            mag_out = mag_a_reg + cske_pkg::MAG_W'(round_up);
        end
        res_mag = {{(cske_pkg::ACC_W-cske_pkg::MAG_W){1'b0}}, mag_out};

        busy_next  = busy_reg;
        fin_next   = 1'b0;
        done_next  = 1'b0;
        op_next    = op_reg;
        neg_next   = neg_reg;
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;

        if (req.start) begin
            busy_next  = 1'b1;
            op_next    = req.op;
            neg_next   = a[cske_pkg::ACC_W-1] ^ b[cske_pkg::G_W-1];
            mag_a_next = abs_a[cske_pkg::MAG_W-1:0];
            mag_b_next = abs_b;
            acc_next   = '0;
            rem_next   = '0;
            cnt_next   = '0;
        end else if (busy_reg) begin
            if (op_reg == cske_pkg::MDU_MUL) begin
                if (mag_b_reg[0]) begin
                    acc_next = acc_reg + mag_a_reg;
                end
                mag_a_next = mag_a_reg << 1;
                mag_b_next = mag_b_reg >> 1;
            end else begin
                rem_next   = ge ? rem_diff[cske_pkg::G_W-1:0] : rem_sh[cske_pkg::G_W-1:0];
                mag_a_next = {mag_a_reg[cske_pkg::MAG_W-2:0], ge};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ((op_reg == cske_pkg::MDU_MUL) ? MUL_LAST : DIV_LAST)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            res_next  = neg_reg ? -res_mag : res_mag;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
        op_reg    <= op_next;
        neg_reg   <= neg_next;
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
    end

    assign sts.busy = busy_reg | fin_reg;
    assign sts.done = done_reg;
    assign res      = res_reg;

endmodule
`default_nettype wire

// ===== src/clock_skew_rls_estimator_unit.sv =====
// Work: the first sample is only stored; the two-point fit takes 8 multiplies;
//   each later sample takes 13 multiplies and 4 divides, all on the one shared
//   multiply/divide unit.
// Throughput: one word at a time; s_tready is high only while the sequencer is idle.
// A finished result sits in the output register and may wait while a new word is taken.
// Reset: synchronous, active-low aresetn; fit phase, fit state and output valid cleared.
`default_nettype none
`include "clock_skew_rls_estimator_unit_defines.svh"
module clock_skew_rls_estimator_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] sample_period, [31:16] sample_offset
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // [47:0] skew_estimate, [95:48] intercept_estimate
    output logic [0:0]       m_tuser    // [0] from_initial_fit
);

    // sequencer and sample state
    cske_pkg::state_t state_reg, state_next;
    logic             issued_reg, issued_next;
    cske_pkg::phase_t phase_reg, phase_next;
    cske_pkg::smp_t   x_reg, x_next;
    cske_pkg::smp_t   y_reg, y_next;
    cske_pkg::smp_t   prev_reg, prev_next;

    // inverse Gram matrix G00, G01, G10, G11 and cross sums
    cske_pkg::g_t     g_reg [4];
    cske_pkg::g_t     g_next [4];
    cske_pkg::g_t     s0_reg, s0_next;
    cske_pkg::g_t     s1_reg, s1_next;

    // update scratch
    cske_pkg::g_t     w0_reg, w0_next;
    cske_pkg::g_t     w1_reg, w1_next;
    cske_pkg::g_t     u0_reg, u0_next;
    cske_pkg::g_t     u1_reg, u1_next;
    cske_pkg::g_t     p_reg, p_next;
    logic [1:0]       k_reg, k_next;
    cske_pkg::acc_t   prod_reg, prod_next;
    cske_pkg::est_t   skew_tmp_reg, skew_tmp_next;
    cske_pkg::est_t   ic_tmp_reg, ic_tmp_next;
    logic             init_reg, init_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    cske_pkg::est_t   m_skew_reg, m_skew_next;
    cske_pkg::est_t   m_ic_reg, m_ic_next;
    logic             m_init_reg, m_init_next;

    cske_pkg::mdu_req_t mdu_req;
    cske_pkg::mdu_sts_t mdu_sts;
    cske_pkg::acc_t     mdu_a;
    cske_pkg::g_t       mdu_b;
    cske_pkg::acc_t     mdu_res;

    cske_pkg::g_t       x1;
    cske_pkg::acc_t     pair_sum;
    cske_pkg::g_t       t_q;
    logic               out_load;

    cske_mdu u_mdu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mdu_req),
        .a       (mdu_a),
        .b       (mdu_b),
        .sts     (mdu_sts),
        .res     (mdu_res)
    );

    always_comb begin
        x1       = cske_pkg::g_t'(cske_pkg::ext16(x_reg) - cske_pkg::ACC_UNIT);
        pair_sum = prod_reg + mdu_res;
        t_q      = cske_pkg::sat64(mdu_res);
        out_load = (state_reg == cske_pkg::ST_OUT) && (!m_valid_reg || m_tready);

        state_next    = state_reg;
        issued_next   = issued_reg;
        phase_next    = phase_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        prev_next     = prev_reg;
        for (int i = 0; i < 4; i++) begin
            g_next[i] = g_reg[i];
        end
        s0_next       = s0_reg;
        s1_next       = s1_reg;
        w0_next       = w0_reg;
        w1_next       = w1_reg;
        u0_next       = u0_reg;
        u1_next       = u1_reg;
        p_next        = p_reg;
        k_next        = k_reg;
        prod_next     = prod_reg;
        skew_tmp_next = skew_tmp_reg;
        ic_tmp_next   = ic_tmp_reg;
        init_next     = init_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_skew_next   = m_skew_reg;
        m_ic_next     = m_ic_reg;
        m_init_next   = m_init_reg;

        mdu_req.start = 1'b0;
        mdu_req.op    = cske_pkg::MDU_MUL;
        mdu_a         = '0;
        mdu_b         = '0;

        // every arithmetic state issues one operation and waits for it
        if (state_reg != cske_pkg::ST_IDLE && state_reg != cske_pkg::ST_OUT) begin
            mdu_req.start = !issued_reg;
            issued_next   = !mdu_sts.done;
        end

        unique case (state_reg)
            cske_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    x_next = s_tdata[15:0];
                    y_next = s_tdata[31:16];
                    case (phase_reg)
                        cske_pkg::PH_EMPTY: begin
                            prev_next  = s_tdata[31:16];
                            phase_next = cske_pkg::PH_ONE;
                        end
                        cske_pkg::PH_ONE: state_next = cske_pkg::ST_I_SQ1;
                        default:          state_next = cske_pkg::ST_U_XG0;
                    endcase
                end
            end
            // two-point fit from (x-1, stored y) and (x, y)
            cske_pkg::ST_I_SQ1: begin
                mdu_a = cske_pkg::ext64(x1);
                mdu_b = x1;
                if (mdu_sts.done) begin
                    prod_next  = mdu_res;
                    state_next = cske_pkg::ST_I_SQ2;
                end
            end
            cske_pkg::ST_I_SQ2: begin
                mdu_a = cske_pkg::ext16(x_reg);
                mdu_b = cske_pkg::g_t'(cske_pkg::ext16(x_reg));
                if (mdu_sts.done) begin
                    g_next[0]  = cske_pkg::G_TWO;
                    g_next[1]  = cske_pkg::sat64((cske_pkg::ACC_UNIT
                                 - (cske_pkg::ext16(x_reg) <<< 1)) <<< cske_pkg::FRAC_BITS);
                    g_next[2]  = g_next[1];
                    g_next[3]  = cske_pkg::sat64(pair_sum <<< cske_pkg::FRAC_BITS);
                    state_next = cske_pkg::ST_I_XY1;
                end
            end
            cske_pkg::ST_I_XY1: begin
                mdu_a = cske_pkg::ext64(x1);
                mdu_b = cske_pkg::g_t'(cske_pkg::ext16(prev_reg));
                if (mdu_sts.done) begin
                    prod_next  = mdu_res;
                    state_next = cske_pkg::ST_I_XY2;
                end
            end
            cske_pkg::ST_I_XY2: begin
                mdu_a = cske_pkg::ext16(x_reg);
                mdu_b = cske_pkg::g_t'(cske_pkg::ext16(y_reg));
                if (mdu_sts.done) begin
                    s0_next    = pair_sum[cske_pkg::G_W-1:0];
                    s1_next    = cske_pkg::g_t'(cske_pkg::ext16(prev_reg)
                                 + cske_pkg::ext16(y_reg));
                    phase_next = cske_pkg::PH_FIT;
                    init_next  = 1'b1;
                    state_next = cske_pkg::ST_E_SK1;
                end
            end
            // rank-one update: w = G'x, u = Gx, p = 1 + x'w
            cske_pkg::ST_U_XG0: begin
                mdu_a = cske_pkg::ext64(g_reg[0]);
                mdu_b = cske_pkg::g_t'(cske_pkg::ext16(x_reg));
                if (mdu_sts.done) begin
                    w0_next    = cske_pkg::sat64(mdu_res + cske_pkg::ext64(g_reg[2]));
                    u0_next    = cske_pkg::sat64(mdu_res + cske_pkg::ext64(g_reg[1]));
                    state_next = cske_pkg::ST_U_XG1;
                end
            end
            cske_pkg::ST_U_XG1: begin
                mdu_a = cske_pkg::ext64(g_reg[1]);
                mdu_b = cske_pkg::g_t'(cske_pkg::ext16(x_reg));
                if (mdu_sts.done) begin
                    w1_next    = cske_pkg::sat64(mdu_res + cske_pkg::ext64(g_reg[3]));
                    state_next = cske_pkg::ST_U_XG2;
                end
            end
            cske_pkg::ST_U_XG2: begin
                mdu_a = cske_pkg::ext64(g_reg[2]);
                mdu_b = cske_pkg::g_t'(cske_pkg::ext16(x_reg));
                if (mdu_sts.done) begin
                    u1_next    = cske_pkg::sat64(mdu_res + cske_pkg::ext64(g_reg[3]));
                    state_next = cske_pkg::ST_U_P;
                end
            end
            cske_pkg::ST_U_P: begin
                mdu_a = cske_pkg::ext64(w0_reg);
                mdu_b = cske_pkg::g_t'(cske_pkg::ext16(x_reg));
                if (mdu_sts.done) begin
                    p_next     = cske_pkg::sat64(mdu_res + cske_pkg::ONE_Q
                                 + cske_pkg::ext64(w1_reg));
                    k_next     = '0;
                    state_next = cske_pkg::ST_U_MUL;
                end
            end
            // term k: u[k/2] * w[k%2], then / p
            cske_pkg::ST_U_MUL: begin
                mdu_a = cske_pkg::ext64(k_reg[1] ? u1_reg : u0_reg);
                mdu_b = k_reg[0] ? w1_reg : w0_reg;
                if (mdu_sts.done) begin
                    prod_next  = mdu_res;
                    state_next = cske_pkg::ST_U_DIV;
                end
            end
            cske_pkg::ST_U_DIV: begin
                mdu_req.op = cske_pkg::MDU_DIV;
                mdu_a      = prod_reg;
                mdu_b      = p_reg;
                if (mdu_sts.done) begin
                    g_next[k_reg] = cske_pkg::sat64(cske_pkg::ext64(g_reg[k_reg])
                                    - cske_pkg::ext64(t_q));
                    k_next        = k_reg + 1'b1;
                    state_next    = (k_reg == 2'd3) ? cske_pkg::ST_U_XY : cske_pkg::ST_U_MUL;
                end
            end
            cske_pkg::ST_U_XY: begin
                mdu_a = cske_pkg::ext16(x_reg);
                mdu_b = cske_pkg::g_t'(cske_pkg::ext16(y_reg));
                if (mdu_sts.done) begin
                    s0_next    = cske_pkg::sat64(cske_pkg::ext64(s0_reg) + mdu_res);
                    s1_next    = cske_pkg::sat64(cske_pkg::ext64(s1_reg)
                                 + cske_pkg::ext16(y_reg));
                    init_next  = 1'b0;
                    state_next = cske_pkg::ST_E_SK1;
                end
            end
            // estimates: G * S
            cske_pkg::ST_E_SK1: begin
                mdu_a = cske_pkg::ext64(g_reg[0]);
                mdu_b = s0_reg;
                if (mdu_sts.done) begin
                    prod_next  = mdu_res;
                    state_next = cske_pkg::ST_E_SK2;
                end
            end
            cske_pkg::ST_E_SK2: begin
                mdu_a = cske_pkg::ext64(g_reg[1]);
                mdu_b = s1_reg;
                if (mdu_sts.done) begin
                    skew_tmp_next = cske_pkg::sat48(pair_sum);
                    state_next    = cske_pkg::ST_E_IC1;
                end
            end
            cske_pkg::ST_E_IC1: begin
                mdu_a = cske_pkg::ext64(g_reg[2]);
                mdu_b = s0_reg;
                if (mdu_sts.done) begin
                    prod_next  = mdu_res;
                    state_next = cske_pkg::ST_E_IC2;
                end
            end
            cske_pkg::ST_E_IC2: begin
                mdu_a = cske_pkg::ext64(g_reg[3]);
                mdu_b = s1_reg;
                if (mdu_sts.done) begin
                    ic_tmp_next = cske_pkg::sat48(pair_sum);
                    state_next  = cske_pkg::ST_OUT;
                end
            end
            // wait for the output register to free up
            cske_pkg::ST_OUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_skew_next  = skew_tmp_reg;
                    m_ic_next    = ic_tmp_reg;
                    m_init_next  = init_reg;
                    state_next   = cske_pkg::ST_IDLE;
                end
            end
            default: state_next = cske_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cske_pkg::ST_IDLE;
            issued_reg  <= 1'b0;
            phase_reg   <= cske_pkg::PH_EMPTY;
            prev_reg    <= '0;
            for (int i = 0; i < 4; i++) begin
                g_reg[i] <= '0;
            end
            s0_reg      <= '0;
            s1_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            issued_reg  <= issued_next;
            phase_reg   <= phase_next;
            prev_reg    <= prev_next;
            for (int i = 0; i < 4; i++) begin
                g_reg[i] <= g_next[i];
            end
            s0_reg      <= s0_next;
            s1_reg      <= s1_next;
            m_valid_reg <= m_valid_next;
        end
        x_reg        <= x_next;
        y_reg        <= y_next;
        w0_reg       <= w0_next;
        w1_reg       <= w1_next;
        u0_reg       <= u0_next;
        u1_reg       <= u1_next;
        p_reg        <= p_next;
        k_reg        <= k_next;
        prod_reg     <= prod_next;
        skew_tmp_reg <= skew_tmp_next;
        ic_tmp_reg   <= ic_tmp_next;
        init_reg     <= init_next;
        m_skew_reg   <= m_skew_next;
        m_ic_reg     <= m_ic_next;
        m_init_reg   <= m_init_next;
    end

    assign s_tready   = (state_reg == cske_pkg::ST_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {m_ic_reg, m_skew_reg};
    assign m_tuser[0] = m_init_reg;

    `CSKE_ASSERT(a_idle_unit_free, aclk, aresetn, s_tready |-> !mdu_sts.busy, "word taken while unit busy")
    `CSKE_ASSERT(a_done_issued, aclk, aresetn, mdu_sts.done |-> issued_reg, "unit result without request")
    `CSKE_ASSERT(a_no_restart, aclk, aresetn, mdu_req.start |-> !mdu_sts.busy, "unit restarted while busy")
    `CSKE_ASSERT_NEXT(a_out_load, aclk, aresetn, out_load, m_tvalid, "result load lost")

endmodule
`default_nettype wire
